// ----- hw/rtl/skyp_pkg.sv -----
`default_nettype none

package skyp_pkg;

   localparam int MAX_POINTS     = 64;
   localparam int MAX_DIMS       = 10;
   localparam int COORD_WIDTH    = 32;
   localparam int CFG_W          = 4;
   localparam int NUM_DIMS_RESET = 2;

   localparam int PT_W  = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int DIM_W = $clog2(MAX_DIMS + 1);
   localparam int DIX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // value seen for a coordinate that a short point never received
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});

   typedef struct packed {
      logic load;
      logic start;
      logic next_k;
      logic next_j;
      logic drop;
      logic next_i;
      logic push;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic set_last;
      logic set_empty;
      logic j_eq_i;
      logic j_last;
      logic i_last;
      logic k_last;
      logic ge;
      logic dom;
      logic sky;
      logic pend_valid;
      logic out_free;
   } status_type;

   function automatic logic [DIM_W-1:0] eff_dims(input logic [CFG_W-1:0] cfg);
      logic [DIM_W-1:0] d;
      if (cfg == '0) begin
         d = DIM_W'(1);
      end else if (32'(cfg) > MAX_DIMS) begin
         d = DIM_W'(MAX_DIMS);
      end else begin
         d = DIM_W'(cfg);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/skyline_point_finder.sv -----
`default_nettype none

// Skyline point finder. Coordinates stream in one per beat while req_stall is low;
// every num_dims beats form a point, and up to 64 points are kept in an on-chip
// store. The beat with last_of_set closes the set and, if the set holds a complete
// point, starts a nested-loop pass that raises req_stall until it is done. The pass
// compares every ordered pair of stored points dimension by dimension, each
// coordinate compare being a store read, then a compare, and leaves a pair at its
// first losing dimension and a point as soon as something dominates it. Skyline
// indices come out in ascending order, the final one with last_of_run set, overflow
// and points_kept repeated on each beat. Full sets drop further complete points and
// flag overflow; a trailing partial point is dropped. The store needs no clearing
// after reset. num_dims is to be written on the csr channel between sets; the block
// does not enforce this. 0 counts as 1 and values above 10 as 10.
module skyline_point_finder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [skyp_pkg::CFG_W-1:0]  csr_num_dims,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire skyp_pkg::coord_type         req_coordinate,
   input  wire logic                        req_last_of_set,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [skyp_pkg::PT_W-1:0]        rsp_point_index,
   output logic                             rsp_last_of_run,
   output logic                             rsp_overflow,
   output logic [skyp_pkg::CNT_W-1:0]       rsp_points_kept
);
   import skyp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !reset;

   skyp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   skyp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr_valid && csr_ready),
      .csr_num_dims    (csr_num_dims),
      .req_coordinate  (req_coordinate),
      .req_last_of_set (req_last_of_set),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_point_index (rsp_point_index),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_overflow    (rsp_overflow),
      .rsp_points_kept (rsp_points_kept)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/skyp_ctrl.sv -----
`default_nettype none

module skyp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire skyp_pkg::status_type  status,
   output skyp_pkg::cmd_type          cmd,
   output logic                       req_stall
);
   import skyp_pkg::*;

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_CMP    = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = reset || (state_ff != ST_LOAD);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               if (status.set_last && !status.set_empty) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            // a point is never compared against itself
            if (status.j_eq_i) begin
               if (status.j_last) begin
                  state_in = ST_DECIDE;
               end else begin
                  cmd.next_j = 1'b1;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (!status.ge || (status.k_last && !status.dom)) begin
               if (status.j_last) begin
                  state_in = ST_DECIDE;
               end else begin
                  cmd.next_j = 1'b1;
                  state_in   = ST_READ;
               end
            end else if (status.k_last) begin
               cmd.drop = 1'b1;
               state_in = ST_DECIDE;
            end else begin
               cmd.next_k = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_DECIDE: begin
            if (!status.sky || !status.pend_valid || status.out_free) begin
               cmd.push = status.sky;
               if (status.i_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.next_i = 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_LOAD;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/skyp_dp.sv -----
`default_nettype none

module skyp_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire skyp_pkg::cmd_type             cmd,
   input  wire logic                          csr_write,
   input  wire logic [skyp_pkg::CFG_W-1:0]    csr_num_dims,
   input  wire skyp_pkg::coord_type           req_coordinate,
   input  wire logic                          req_last_of_set,
   input  wire logic                          rsp_stall,
   output skyp_pkg::status_type               status,
   output logic                               rsp_valid,
   output logic [skyp_pkg::PT_W-1:0]          rsp_point_index,
   output logic                               rsp_last_of_run,
   output logic                               rsp_overflow,
   output logic [skyp_pkg::CNT_W-1:0]         rsp_points_kept
);
   import skyp_pkg::*;

   coord_type        coord_mem [MAX_POINTS][MAX_DIMS];
   logic [DIM_W-1:0] len_mem   [MAX_POINTS];

   logic [CFG_W-1:0] num_dims_ff;
   logic [CNT_W-1:0] pc_ff, pc_in, pc_next;
   logic [DIM_W-1:0] dc_ff, dc_in, dc_inc, dc_next;
   logic             ovf_ff, ovf_in, ovf_next;
   logic [DIM_W-1:0] dims_eff;
   logic             room, complete;

   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [DIM_W-1:0] dims_pass_ff, dims_pass_in;
   logic             ovf_pass_ff, ovf_pass_in;

   logic [PT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [DIX_W-1:0] k_ff, k_in;
   logic             strict_ff, strict_in, sky_ff, sky_in;

   coord_type        rd_a_ff, rd_b_ff, val_a, val_b;
   logic [DIM_W-1:0] len_a_ff, len_b_ff;
   logic             ge, gt;

   logic             pend_valid_ff, pend_valid_in;
   logic [PT_W-1:0]  pend_idx_ff, pend_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic [CNT_W-1:0] rsp_kept_ff, rsp_kept_in;
   logic             out_free;

   // coordinate intake
   assign dims_eff = eff_dims(num_dims_ff);
   assign room     = pc_ff < CNT_W'(MAX_POINTS);
   assign dc_inc   = dc_ff + DIM_W'(1);
   assign complete = dc_inc >= dims_eff;
   assign dc_next  = complete ? '0 : dc_inc;
   assign pc_next  = (complete && room) ? pc_ff + CNT_W'(1) : pc_ff;
   assign ovf_next = ovf_ff || (complete && !room);

   always_comb begin
      pc_in        = pc_ff;
      dc_in        = dc_ff;
      ovf_in       = ovf_ff;
      kept_in      = kept_ff;
      dims_pass_in = dims_pass_ff;
      ovf_pass_in  = ovf_pass_ff;
      if (cmd.load) begin
         pc_in  = pc_next;
         dc_in  = dc_next;
         ovf_in = ovf_next;
         if (req_last_of_set) begin
            // freeze the set for the pass and start the next one empty
            pc_in        = '0;
            dc_in        = '0;
            ovf_in       = 1'b0;
            kept_in      = pc_next;
            dims_pass_in = dims_eff;
            ovf_pass_in  = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= CFG_W'(NUM_DIMS_RESET);
         pc_ff       <= '0;
         dc_ff       <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            num_dims_ff <= csr_num_dims;
         end
         pc_ff  <= pc_in;
         dc_ff  <= dc_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      kept_ff      <= kept_in;
      dims_pass_ff <= dims_pass_in;
      ovf_pass_ff  <= ovf_pass_in;
   end

   // point store: one write port for intake, two read ports for the pass
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         coord_mem[pc_ff[PT_W-1:0]][dc_ff[DIX_W-1:0]] <= req_coordinate;
         len_mem[pc_ff[PT_W-1:0]]                     <= dc_inc;
      end
      rd_a_ff  <= coord_mem[j_ff][k_ff];
      rd_b_ff  <= coord_mem[i_ff][k_ff];
      len_a_ff <= len_mem[j_ff];
      len_b_ff <= len_mem[i_ff];
   end

   // candidate j against point i, one dimension per compare
   assign val_a = (DIM_W'(k_ff) < len_a_ff) ? rd_a_ff : COORD_MIN;
   assign val_b = (DIM_W'(k_ff) < len_b_ff) ? rd_b_ff : COORD_MIN;
   assign ge    = val_a >= val_b;
   assign gt    = val_a > val_b;

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      strict_in = strict_ff;
      sky_in    = sky_ff;
      if (cmd.start) begin
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         strict_in = 1'b0;
         sky_in    = 1'b1;
      end
      if (cmd.next_k) begin
         k_in      = k_ff + DIX_W'(1);
         strict_in = strict_ff || gt;
      end
      if (cmd.next_j) begin
         j_in      = j_ff + PT_W'(1);
         k_in      = '0;
         strict_in = 1'b0;
      end
      if (cmd.drop) begin
         sky_in = 1'b0;
      end
      if (cmd.next_i) begin
         i_in      = i_ff + PT_W'(1);
         j_in      = '0;
         k_in      = '0;
         strict_in = 1'b0;
         sky_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      strict_ff <= strict_in;
      sky_ff    <= sky_in;
   end

   // hold each skyline index until the next one shows whether it is the last
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_kept_in   = rsp_kept_ff;
      if ((cmd.push && pend_valid_ff) || cmd.flush) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = pend_idx_ff;
         rsp_last_in  = cmd.flush;
         rsp_ovf_in   = ovf_pass_ff;
         rsp_kept_in  = kept_ff;
      end
      if (cmd.push) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = i_ff;
      end
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_kept_ff <= rsp_kept_in;
   end

   assign status.set_last   = req_last_of_set;
   assign status.set_empty  = (pc_next == '0);
   assign status.j_eq_i     = (j_ff == i_ff);
   assign status.j_last     = ((CNT_W'(j_ff) + CNT_W'(1)) == kept_ff);
   assign status.i_last     = ((CNT_W'(i_ff) + CNT_W'(1)) == kept_ff);
   assign status.k_last     = ((DIM_W'(k_ff) + DIM_W'(1)) == dims_pass_ff);
   assign status.ge         = ge;
   assign status.dom        = strict_ff || gt;
   assign status.sky        = sky_ff;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_points_kept = rsp_kept_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/skyp_checker.sv -----
`default_nettype none

module skyp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [skyp_pkg::PT_W-1:0]   rsp_point_index,
   input wire logic                        rsp_last_of_run,
   input wire logic                        rsp_overflow,
   input wire logic [skyp_pkg::CNT_W-1:0]  rsp_points_kept
);
   import skyp_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_index)
         && $stable(rsp_last_of_run) && $stable(rsp_points_kept))
      else $error("stalled result beat changed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CNT_W'(rsp_point_index) < rsp_points_kept))
      else $error("skyline index outside the kept points");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_points_kept == CNT_W'(MAX_POINTS)))
      else $error("overflow reported on a set that was not full");

   // a non-final index means the pass still owns the block
   a_pass_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input open while a set is still being reported");

endmodule

bind skyline_point_finder skyp_checker u_skyp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_point_index (rsp_point_index),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_overflow    (rsp_overflow),
   .rsp_points_kept (rsp_points_kept)
);

`default_nettype wire
